FILE: sv/vn_pkg.sv
// Shared widths, pipeline depths and types for the vector normalizer.
package vn_pkg;

  localparam int unsigned COMP_W    = 32;  // input component, Q16.16
  localparam int unsigned SQ_W      = 64;  // sum of squares, Q32.32
  localparam int unsigned LEN_W     = 32;  // length, Q16.16
  localparam int unsigned UNIT_W    = 18;  // unit component, Q1.16
  localparam int unsigned FRAC_W    = 17;  // numerator shift (Q1.16 plus round bit)
  localparam int unsigned REM_W     = LEN_W + 2;
  localparam int unsigned DEN_W     = LEN_W + 1;
  localparam int unsigned NUM_W     = COMP_W + FRAC_W;

  localparam int unsigned SQRT_STEPS = SQ_W / 2;
  localparam int unsigned SQRT_LAT   = SQRT_STEPS + 2;
  localparam int unsigned DIV_STEPS  = UNIT_W;
  localparam int unsigned DIV_LAT    = DIV_STEPS + 2;
  localparam int unsigned FRONT_LAT  = 3;
  localparam int unsigned TOTAL_LAT  = FRONT_LAT + SQRT_LAT + DIV_LAT;

  localparam logic [UNIT_W-1:0] UNIT_ONE = UNIT_W'(65536);

  // magnitudes and signs that ride alongside the length computation
  typedef struct packed {
    logic [COMP_W-1:0] mx;
    logic [COMP_W-1:0] my;
    logic [COMP_W-1:0] mz;
    logic              nx;
    logic              ny;
    logic              nz;
  } side_t;

endpackage

FILE: sv/vn_sqrt.sv
// Pipelined integer square root, one result bit per stage, rounded to nearest.
module vn_sqrt (
  input  logic                       clk_i,
  input  logic [vn_pkg::SQ_W-1:0]    s_i,
  output logic [vn_pkg::LEN_W-1:0]   len_o
);

  localparam int unsigned N = vn_pkg::SQRT_STEPS;

  logic [vn_pkg::SQ_W-1:0]  s_q    [N+1];
  logic [vn_pkg::REM_W-1:0] rem_q  [N+1];
  logic [vn_pkg::LEN_W-1:0] root_q [N+1];
  logic [vn_pkg::LEN_W-1:0] len_q;

  always_ff @(posedge clk_i) begin
    s_q[0]    <= s_i;
    rem_q[0]  <= '0;
    root_q[0] <= '0;
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [vn_pkg::REM_W+1:0] t;
    logic [vn_pkg::REM_W+1:0] trial;
    logic                     ge;
    assign t     = {rem_q[k], s_q[k][vn_pkg::SQ_W-1 -: 2]};
    assign trial = {2'b00, root_q[k], 2'b01};
    assign ge    = (t >= trial);
    always_ff @(posedge clk_i) begin
      s_q[k+1]    <= {s_q[k][vn_pkg::SQ_W-3:0], 2'b00};
      rem_q[k+1]  <= ge ? vn_pkg::REM_W'(t - trial) : vn_pkg::REM_W'(t);
      root_q[k+1] <= {root_q[k][vn_pkg::LEN_W-2:0], ge};
    end
  end

  // remainder above root means the true root is past the half point
  always_ff @(posedge clk_i) begin
    len_q <= root_q[N] + vn_pkg::LEN_W'(rem_q[N] > {2'b00, root_q[N]});
  end

  assign len_o = len_q;

endmodule

FILE: sv/vn_div.sv
// Pipelined restoring divider: one component magnitude over length, to signed Q1.16.
module vn_div (
  input  logic                       clk_i,
  input  logic [vn_pkg::COMP_W-1:0]  mag_i,
  input  logic                       neg_i,
  input  logic                       zero_i,
  input  logic [vn_pkg::LEN_W-1:0]   len_i,
  output logic [vn_pkg::UNIT_W-1:0]  unit_o
);

  localparam int unsigned N = vn_pkg::DIV_STEPS;

  logic [vn_pkg::NUM_W-1:0]  num;
  logic [vn_pkg::DEN_W-1:0]  den_q [N+1];
  logic [vn_pkg::DEN_W-1:0]  r_q   [N+1];
  logic [N-1:0]              q_q   [N+1];
  logic                      neg_q [N+1];
  logic                      zero_q[N+1];
  logic [vn_pkg::UNIT_W-1:0] unit_q;
  logic [vn_pkg::UNIT_W-1:0] qc;

  // numerator mag*2^17 + len, denominator 2*len: rounds half away from zero
  assign num = {mag_i, vn_pkg::FRAC_W'(0)} + vn_pkg::NUM_W'(len_i);

  always_ff @(posedge clk_i) begin
    den_q[0]  <= {len_i, 1'b0};
    r_q[0]    <= vn_pkg::DEN_W'(num[vn_pkg::NUM_W-1:N]);
    q_q[0]    <= num[N-1:0];
    neg_q[0]  <= neg_i;
    zero_q[0] <= zero_i;
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [vn_pkg::DEN_W:0] t;
    logic                   ge;
    assign t  = {r_q[k], q_q[k][N-1]};
    assign ge = (t >= {1'b0, den_q[k]});
    always_ff @(posedge clk_i) begin
      den_q[k+1]  <= den_q[k];
      r_q[k+1]    <= ge ? vn_pkg::DEN_W'(t - {1'b0, den_q[k]}) : vn_pkg::DEN_W'(t);
      q_q[k+1]    <= {q_q[k][N-2:0], ge};
      neg_q[k+1]  <= neg_q[k];
      zero_q[k+1] <= zero_q[k];
    end
  end

  assign qc = (q_q[N] > vn_pkg::UNIT_ONE) ? vn_pkg::UNIT_ONE : q_q[N];

  always_ff @(posedge clk_i) begin
    if (zero_q[N]) begin
      unit_q <= '0;
    end else if (neg_q[N]) begin
      unit_q <= '0 - qc;
    end else begin
      unit_q <= qc;
    end
  end

  assign unit_o = unit_q;

endmodule

FILE: sv/vec3_normalize.sv
// Top level: fully pipelined three-component vector normalizer.
//
// One word enters per clock whenever start_i is high; busy_o is always low,
// since the pipeline never stalls and the receiver cannot hold results off.
// Each word comes back as a one-cycle done_o strobe with length_o (Q16.16,
// square root rounded to nearest), the unit vector in signed Q1.16 and
// zero_length_o. The latency is set by the square root (32 one-bit stages
// plus rounding) followed by an 18-stage restoring divider per component; a
// zero vector yields a zero unit vector and zero_length_o.
module vec3_normalize (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [vn_pkg::COMP_W-1:0]  x_in_i,
  input  logic [vn_pkg::COMP_W-1:0]  y_in_i,
  input  logic [vn_pkg::COMP_W-1:0]  z_in_i,
  output logic                       done_o,
  output logic [vn_pkg::UNIT_W-1:0]  x_unit_o,
  output logic [vn_pkg::UNIT_W-1:0]  y_unit_o,
  output logic [vn_pkg::UNIT_W-1:0]  z_unit_o,
  output logic [vn_pkg::LEN_W-1:0]   length_o,
  output logic                       zero_length_o
);

  localparam int unsigned SL = vn_pkg::SQRT_LAT;
  localparam int unsigned DL = vn_pkg::DIV_LAT;
  localparam int unsigned TL = vn_pkg::TOTAL_LAT;

  logic [TL-1:0]            vld_q;
  vn_pkg::side_t            side_a_q, side_b_q, side_c_q;
  vn_pkg::side_t            side_d_q [SL];
  logic [vn_pkg::SQ_W-1:0]  sqx_q, sqy_q, sqz_q, sum_q;
  logic [vn_pkg::LEN_W-1:0] len;
  logic                     zero;
  logic [vn_pkg::LEN_W-1:0] len_dq  [DL];
  logic                     zero_dq [DL];

  assign busy_o = 1'b0;

  // valid line, one bit per pipeline stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[TL-2:0], start_i};
    end
  end

  // stage A: magnitudes and signs
  always_ff @(posedge clk_i) begin
    side_a_q.nx <= x_in_i[vn_pkg::COMP_W-1];
    side_a_q.ny <= y_in_i[vn_pkg::COMP_W-1];
    side_a_q.nz <= z_in_i[vn_pkg::COMP_W-1];
    side_a_q.mx <= x_in_i[vn_pkg::COMP_W-1] ? '0 - x_in_i : x_in_i;
    side_a_q.my <= y_in_i[vn_pkg::COMP_W-1] ? '0 - y_in_i : y_in_i;
    side_a_q.mz <= z_in_i[vn_pkg::COMP_W-1] ? '0 - z_in_i : z_in_i;
  end

  // stage B: one 32x32 square per component
  always_ff @(posedge clk_i) begin
    side_b_q <= side_a_q;
    sqx_q    <= vn_pkg::SQ_W'(side_a_q.mx) * vn_pkg::SQ_W'(side_a_q.mx);
    sqy_q    <= vn_pkg::SQ_W'(side_a_q.my) * vn_pkg::SQ_W'(side_a_q.my);
    sqz_q    <= vn_pkg::SQ_W'(side_a_q.mz) * vn_pkg::SQ_W'(side_a_q.mz);
  end

  // stage C: sum of squares, each square at most 2^62 so no overflow
  always_ff @(posedge clk_i) begin
    side_c_q <= side_b_q;
    sum_q    <= sqx_q + sqy_q + sqz_q;
  end

  vn_sqrt u_sqrt (
    .clk_i (clk_i),
    .s_i   (sum_q),
    .len_o (len)
  );

  // magnitudes ride along with the root
  always_ff @(posedge clk_i) begin
    side_d_q[0] <= side_c_q;
    for (int i = 1; i < SL; i++) begin
      side_d_q[i] <= side_d_q[i-1];
    end
  end

  // rounded root is zero only for the zero vector
  assign zero = (len == '0);

  vn_div u_div_x (
    .clk_i  (clk_i),
    .mag_i  (side_d_q[SL-1].mx),
    .neg_i  (side_d_q[SL-1].nx),
    .zero_i (zero),
    .len_i  (len),
    .unit_o (x_unit_o)
  );

  vn_div u_div_y (
    .clk_i  (clk_i),
    .mag_i  (side_d_q[SL-1].my),
    .neg_i  (side_d_q[SL-1].ny),
    .zero_i (zero),
    .len_i  (len),
    .unit_o (y_unit_o)
  );

  vn_div u_div_z (
    .clk_i  (clk_i),
    .mag_i  (side_d_q[SL-1].mz),
    .neg_i  (side_d_q[SL-1].nz),
    .zero_i (zero),
    .len_i  (len),
    .unit_o (z_unit_o)
  );

  // length and flag wait out the divider
  always_ff @(posedge clk_i) begin
    len_dq[0]  <= len;
    zero_dq[0] <= zero;
    for (int i = 1; i < DL; i++) begin
      len_dq[i]  <= len_dq[i-1];
      zero_dq[i] <= zero_dq[i-1];
    end
  end

  assign done_o        = vld_q[TL-1];
  assign length_o      = len_dq[DL-1];
  assign zero_length_o = zero_dq[DL-1];

endmodule
